/* design/mps_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mps_pkg
// shared codes and percentile constants for the mode and percentile engine
// ----------------------------------------------------------------------------
package mps_pkg;

  localparam int unsigned FRAC_W = 7;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_FINISH = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    STAT_MODE   = 3'd0,
    STAT_MEDIAN = 3'd1,
    STAT_P25    = 3'd2,
    STAT_P75    = 3'd3,
    STAT_P90    = 3'd4,
    STAT_P95    = 3'd5,
    STAT_P99    = 3'd6,
    STAT_NONE   = 3'd7
  } stat_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_ANSWER   = 2'd2,
    ST_NO_ANS   = 2'd3
  } status_t;

  typedef struct packed {
    logic [FRAC_W-1:0] num;
    logic [FRAC_W-1:0] den;
  } frac_t;

  function automatic frac_t stat_frac(input stat_t s);
    frac_t f;
    unique case (s)
      STAT_MEDIAN: f = '{num: 7'd1,  den: 7'd2};
      STAT_P25:    f = '{num: 7'd1,  den: 7'd4};
      STAT_P75:    f = '{num: 7'd3,  den: 7'd4};
      STAT_P90:    f = '{num: 7'd9,  den: 7'd10};
      STAT_P95:    f = '{num: 7'd95, den: 7'd100};
      STAT_P99:    f = '{num: 7'd99, den: 7'd100};
      default:     f = '{num: 7'd1,  den: 7'd1};
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

/* design/mode_and_percentile_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mode_and_percentile_engine
// sorted value table with counts, reports mode or a percentile on finish
// ----------------------------------------------------------------------------
// An insert beat reads the table one entry at a time (memory read, then
// compare) until it finds the value or its slot and, for a new value, shifts
// the larger entries up one slot at a time (read, then write). A finish beat
// walks the used entries in order through one multiply-add compare unit: the
// mode walks every used entry, a percentile stops once past its target. For
// a finish, an empty table or an unused selector goes straight to the result.
// The table memory has one registered read port, and a stalled result beat
// holds the engine in its result state until it is taken.
// in_tready is high only between beats.
module mode_and_percentile_engine #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [63:0]  in_tdata,   // value
  input  wire logic [3:0]   in_tuser,   // action, statistic
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [135:0]      out_tdata,  // first_value, second_value, picked, zero pad
  output logic [1:0]        out_tuser   // status
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned UW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned FW = mps_pkg::FRAC_W;
  localparam int unsigned PW = CW + FW + 1;
  localparam logic [UW-1:0] DEPTH_U = UW'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    IDLE, S_RD, S_CMP, PLACE, SH_RD, SH_WR, INS_WR, INC_WR, W_RD, W_CMP, DONE
  } state_t;

  state_t            state_r;
  logic [UW-1:0]     used_r, idx_r, pos_r;
  logic [CW-1:0]     total_r;
  logic [63:0]       key_r;
  logic              fin_r;
  logic [FW-1:0]     den_r;
  logic [PW-1:0]     target_r, cumd_r;
  logic              is_mode_r;
  logic [CW-1:0]     best_r;
  logic [1:0]        ties_r, n_r;
  logic [63:0]       sel0_r, sel1_r, best_key_r;
  logic [1:0]        res_status_r;

  logic              out_valid_r;
  logic [1:0]        out_status_r, out_picked_r;
  logic [63:0]       out_first_r, out_second_r;

  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [63:0]       rd_key, wr_key;
  logic [CW-1:0]     rd_cnt, wr_cnt;

  logic              in_fire;
  mps_pkg::stat_t    in_stat;
  mps_pkg::frac_t    in_frac;
  logic [PW-1:0]     cnt_d, after_d;
  logic [UW-1:0]     idx_inc, idx_dec;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == IDLE);
  assign in_stat   = mps_pkg::stat_t'(in_tuser[3:1]);
  assign in_frac   = mps_pkg::stat_frac(in_stat);
  assign cnt_d     = PW'(rd_cnt) * PW'(den_r);
  assign after_d   = cumd_r + cnt_d;
  assign idx_inc   = idx_r + UW'(1);
  assign idx_dec   = idx_r - UW'(1);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_r[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx_r[AW-1:0];
    wr_key  = rd_key;
    wr_cnt  = rd_cnt;
    unique case (state_r)
      S_RD, W_RD: rd_en = 1'b1;
      SH_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_dec[AW-1:0];
      end
      SH_WR: wr_en = 1'b1;
      INS_WR: begin
        wr_en   = 1'b1;
        wr_addr = pos_r[AW-1:0];
        wr_key  = key_r;
        wr_cnt  = CW'(1);
      end
      INC_WR: begin
        wr_en  = 1'b1;
        wr_cnt = rd_cnt + CW'(1);
      end
      default: ;
    endcase
  end

  mps_table #(.DEPTH(TABLE_DEPTH), .CW(CW), .AW(AW)) u_table (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_key_r (rd_key),
    .rd_cnt_r (rd_cnt),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_key   (wr_key),
    .wr_cnt   (wr_cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      used_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        IDLE: begin
          if (in_fire) begin
            key_r      <= in_tdata;
            fin_r      <= (in_tuser[0] == mps_pkg::ACT_FINISH);
            idx_r      <= '0;
            pos_r      <= '0;
            den_r      <= in_frac.den;
            target_r   <= PW'(total_r) * PW'(in_frac.num);
            cumd_r     <= '0;
            is_mode_r  <= (in_stat == mps_pkg::STAT_MODE);
            best_r     <= '0;
            ties_r     <= '0;
            n_r        <= '0;
            sel0_r     <= '0;
            sel1_r     <= '0;
            best_key_r <= '0;
            if (in_tuser[0] == mps_pkg::ACT_FINISH) begin
              if (used_r == '0 || in_stat == mps_pkg::STAT_NONE) begin
                res_status_r <= mps_pkg::ST_NO_ANS;
                state_r      <= DONE;
              end else begin
                state_r <= W_RD;
              end
            end else if (total_r == {CW{1'b1}}) begin
              res_status_r <= mps_pkg::ST_DROPPED;
              state_r      <= DONE;
            end else if (used_r == '0) begin
              state_r <= INS_WR;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_RD: state_r <= S_CMP;
        S_CMP: begin
          if (rd_key == key_r) begin
            state_r <= INC_WR;
          end else if ($signed(rd_key) > $signed(key_r)) begin
            pos_r   <= idx_r;
            state_r <= PLACE;
          end else if (idx_inc == used_r) begin
            pos_r   <= used_r;
            state_r <= PLACE;
          end else begin
            idx_r   <= idx_inc;
            state_r <= S_RD;
          end
        end
        PLACE: begin
          if (used_r == DEPTH_U) begin
            res_status_r <= mps_pkg::ST_DROPPED;
            state_r      <= DONE;
          end else if (used_r == pos_r) begin
            state_r <= INS_WR;
          end else begin
            idx_r   <= used_r;
            state_r <= SH_RD;
          end
        end
        SH_RD: state_r <= SH_WR;
        SH_WR: begin
          idx_r   <= idx_dec;
          state_r <= (idx_dec == pos_r) ? INS_WR : SH_RD;
        end
        INS_WR: begin
          used_r       <= used_r + UW'(1);
          total_r      <= total_r + CW'(1);
          res_status_r <= mps_pkg::ST_INSERTED;
          state_r      <= DONE;
        end
        INC_WR: begin
          total_r      <= total_r + CW'(1);
          res_status_r <= mps_pkg::ST_INSERTED;
          state_r      <= DONE;
        end
        W_RD: state_r <= W_CMP;
        W_CMP: begin
          logic stop;
          logic [1:0] n_nxt;
          stop  = 1'b0;
          n_nxt = n_r;
          if (is_mode_r) begin
            if (rd_cnt == best_r) begin
              if (ties_r != 2'd2) ties_r <= ties_r + 2'd1;
            end else if (rd_cnt > best_r) begin
              best_r     <= rd_cnt;
              best_key_r <= rd_key;
              ties_r     <= 2'd1;
            end
          end else if (after_d >= target_r) begin
            if (cumd_r > target_r) begin
              stop = 1'b1;
            end else begin
              if (n_r == 2'd0) sel0_r <= rd_key;
              if (n_r == 2'd1) sel1_r <= rd_key;
              if (n_r != 2'd2) n_nxt = n_r + 2'd1;
            end
          end
          n_r    <= n_nxt;
          cumd_r <= after_d;
          idx_r  <= idx_inc;
          if (stop || idx_inc == used_r) begin
            state_r <= DONE;
            if (is_mode_r) begin
              logic ok;
              ok = (ties_r == 2'd1 && !(rd_cnt == best_r)) || (rd_cnt > best_r);
              res_status_r <= ok ? mps_pkg::ST_ANSWER : mps_pkg::ST_NO_ANS;
            end else begin
              res_status_r <= (n_nxt == 2'd0) ? mps_pkg::ST_NO_ANS : mps_pkg::ST_ANSWER;
            end
          end else begin
            state_r <= W_RD;
          end
        end
        DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_first_r  <= '0;
            out_second_r <= '0;
            out_picked_r <= '0;
            if (fin_r && res_status_r == mps_pkg::ST_ANSWER) begin
              if (is_mode_r) begin
                out_first_r  <= best_key_r;
                out_picked_r <= 2'd1;
              end else begin
                out_first_r  <= sel0_r;
                out_second_r <= (n_r == 2'd2) ? sel1_r : 64'd0;
                out_picked_r <= n_r;
              end
            end
            if (fin_r) begin
              used_r  <= '0;
              total_r <= '0;
            end
            state_r <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {6'd0, out_picked_r, out_second_r, out_first_r};

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= DEPTH_U) else $error("table fill beyond depth");
  a_total_ge_used: assert property (@(posedge clk) disable iff (!rst_n)
    (CW + UW)'(total_r) >= (CW + UW)'(used_r)) else $error("total below entry count");
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready) else $error("ready right after accepted beat");
  a_picked_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[129:128] != 2'd3) else $error("picked out of range");
`endif

endmodule
`default_nettype wire

/* design/mps_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mps_table
// key and count memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module mps_table #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned CW    = 32,
  parameter int unsigned AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [63:0]        rd_key_r,
  output logic [CW-1:0]      rd_cnt_r,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [63:0]   wr_key,
  input  wire logic [CW-1:0] wr_cnt
);

  logic [63:0]   key_mem [DEPTH];
  logic [CW-1:0] cnt_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      cnt_mem[wr_addr] <= wr_cnt;
    end
    if (rd_en) begin
      rd_key_r <= key_mem[rd_addr];
      rd_cnt_r <= cnt_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
